// ----- src/stam_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the section table address mapper.
// Depends on nothing; every other file imports it.
package stam_pkg;

    localparam int MAX_SECTIONS = 16;
    localparam int WORD_W       = 32;
    localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);
    localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CFG_IDX_W    = 3;
    localparam int DIV_CNT_W    = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] NT_HEADERS_BYTES     = WORD_W'(264);
    localparam logic [WORD_W-1:0] SECTION_HEADER_BYTES = WORD_W'(40);
    localparam logic [WORD_W-1:0] SECTION_ALIGN_RESET  = WORD_W'(4096);
    localparam logic [WORD_W-1:0] FILE_ALIGN_RESET     = WORD_W'(512);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_VALID      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NT_HEADER_OFFSET = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_AREA_SIZE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_ALIGN    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_ALIGN       = CFG_IDX_W'(4);

    typedef enum logic [1:0] {
        KIND_APPEND,
        KIND_ADD,
        KIND_RVA_TO_OFF,
        KIND_OFF_TO_RVA
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK,
        STAT_NOT_FOUND,
        STAT_NO_ROOM,
        STAT_FULL,
        STAT_INVALID
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ROOM,
        ST_LAST_RD,
        ST_LAST_SUM,
        ST_RU_LOAD,
        ST_RU_TEST,
        ST_RU_WAIT,
        ST_RU_STORE,
        ST_LOOK_RD,
        ST_LOOK_CMP,
        ST_LOOK_MAP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] virt_addr;
        logic [WORD_W-1:0] virt_size;
        logic [WORD_W-1:0] raw_ptr;
        logic [WORD_W-1:0] raw_size;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ----- src/stam_req_if.sv -----
`timescale 1ns / 1ps
// Request channel: one operation word with its operands.
// Depends on stam_pkg.
interface stam_req_if import stam_pkg::*; ();

    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [WORD_W-1:0] address;
    logic [WORD_W-1:0] section_size;
    logic [WORD_W-1:0] entry_virtual_address;
    logic [WORD_W-1:0] entry_raw_pointer;
    logic [WORD_W-1:0] entry_raw_size;

    modport source (
        output valid, kind, address, section_size,
               entry_virtual_address, entry_raw_pointer, entry_raw_size,
        input  ready
    );

    modport sink (
        input  valid, kind, address, section_size,
               entry_virtual_address, entry_raw_pointer, entry_raw_size,
        output ready
    );

endinterface

// ----- src/stam_rsp_if.sv -----
`timescale 1ns / 1ps
// Response channel: one result word per request word.
// Depends on stam_pkg.
interface stam_rsp_if import stam_pkg::*; ();

    logic              valid;
    logic              ready;
    status_t           status;
    logic [WORD_W-1:0] mapped_address;
    logic [WORD_W-1:0] placed_raw_offset;
    logic [WORD_W-1:0] placed_raw_size;
    logic [WORD_W-1:0] image_size;

    modport source (
        output valid, status, mapped_address, placed_raw_offset,
               placed_raw_size, image_size,
        input  ready
    );

    modport sink (
        input  valid, status, mapped_address, placed_raw_offset,
               placed_raw_size, image_size,
        output ready
    );

endinterface

// ----- src/stam_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on stam_pkg.
interface stam_cfg_if import stam_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

// ----- src/section_table_address_mapper.sv -----
`timescale 1ns / 1ps
// Section table address mapper: section table memory, sequencer and datapath.
// Depends on stam_pkg, the three channel interfaces and stam_rem_unit.
//
//  Channel | Direction | Carries
//  --------+-----------+-------------------------------------------------
//  cfg     | in        | register index and 32-bit write data
//  req     | in        | operation kind, address and entry operands
//  rsp     | out       | status and four 32-bit result fields
//
// A translation scans the table entries in order until one holds the address.
// An add runs four round-ups through the shared 32-step remainder unit.
// Reset clears the entry count and loads the default alignments.
// A waiting response does not block the next request, but the next result
// is held in the sequencer until the response register is free.
module section_table_address_mapper import stam_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    stam_cfg_if.sink   cfg,
    stam_req_if.sink   req,
    stam_rsp_if.source rsp
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [1:0]        op_reg, op_next;

    logic              valid_cfg_reg;
    logic [WORD_W-1:0] nt_reg;
    logic [WORD_W-1:0] hdr_reg;
    logic [WORD_W-1:0] sa_reg;
    logic [WORD_W-1:0] fa_reg;

    kind_t             kind_reg, kind_next;
    logic [WORD_W-1:0] addr_reg, addr_next;
    logic [WORD_W-1:0] size_reg, size_next;
    logic [WORD_W-1:0] eva_reg, eva_next;
    logic [WORD_W-1:0] erp_reg, erp_next;
    logic [WORD_W-1:0] ers_reg, ers_next;

    status_t           wk_status_reg, wk_status_next;
    logic [WORD_W-1:0] wk_mapped_reg, wk_mapped_next;
    logic [WORD_W-1:0] wk_off_reg, wk_off_next;
    logic [WORD_W-1:0] wk_psize_reg, wk_psize_next;
    logic [WORD_W-1:0] wk_img_reg, wk_img_next;

    logic [WORD_W-1:0] base_va_reg, base_va_next;
    logic [WORD_W-1:0] base_off_reg, base_off_next;
    logic [WORD_W-1:0] ru_v_reg, ru_v_next;
    logic [WORD_W-1:0] ru_a_reg, ru_a_next;
    logic [WORD_W-1:0] ru_res_reg, ru_res_next;
    logic [WORD_W-1:0] diff_reg, diff_next;
    logic [WORD_W-1:0] to_reg, to_next;

    logic              rsp_valid_reg, rsp_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [WORD_W-1:0] out_mapped_reg, out_mapped_next;
    logic [WORD_W-1:0] out_off_reg, out_off_next;
    logic [WORD_W-1:0] out_psize_reg, out_psize_next;
    logic [WORD_W-1:0] out_img_reg, out_img_next;

    entry_t            table_mem [MAX_SECTIONS];
    entry_t            rd_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              mem_we;
    entry_t            wr_row;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              full;
    logic [WORD_W-1:0] room_end;
    logic              room_fail;
    logic [CNT_W-1:0]  last_cnt;
    logic [WORD_W-1:0] from_base;
    logic [WORD_W-1:0] from_len;
    logic [WORD_W-1:0] from_end;
    logic [WORD_W-1:0] to_base;
    logic              hit;
    logic [CNT_W-1:0]  idx_inc;

    stam_rem_unit u_rem (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.status            = out_status_reg;
    assign rsp.mapped_address    = out_mapped_reg;
    assign rsp.placed_raw_offset = out_off_reg;
    assign rsp.placed_raw_size   = out_psize_reg;
    assign rsp.image_size        = out_img_reg;

    always_comb
    begin
        full      = (count_reg == CNT_W'(MAX_SECTIONS));
        room_end  = nt_reg + NT_HEADERS_BYTES + SECTION_HEADER_BYTES
                    + WORD_W'(count_reg) * SECTION_HEADER_BYTES;
        room_fail = (room_end > hdr_reg);
        last_cnt  = count_reg - 1'b1;
        idx_inc   = idx_reg + 1'b1;
        rd_addr   = (state_reg == ST_LAST_RD) ? last_cnt[IDX_W-1:0] : idx_reg[IDX_W-1:0];
        wr_addr   = count_reg[IDX_W-1:0];
        if (kind_reg == KIND_RVA_TO_OFF)
        begin
            from_base = rd_reg.virt_addr;
            from_len  = rd_reg.virt_size;
            to_base   = rd_reg.raw_ptr;
        end
        else
        begin
            from_base = rd_reg.raw_ptr;
            from_len  = rd_reg.raw_size;
            to_base   = rd_reg.virt_addr;
        end
        from_end = from_base + from_len;
        hit      = (addr_reg >= from_base) && (addr_reg < from_end);
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        size_next       = size_reg;
        eva_next        = eva_reg;
        erp_next        = erp_reg;
        ers_next        = ers_reg;
        wk_status_next  = wk_status_reg;
        wk_mapped_next  = wk_mapped_reg;
        wk_off_next     = wk_off_reg;
        wk_psize_next   = wk_psize_reg;
        wk_img_next     = wk_img_reg;
        base_va_next    = base_va_reg;
        base_off_next   = base_off_reg;
        ru_v_next       = ru_v_reg;
        ru_a_next       = ru_a_reg;
        ru_res_next     = ru_res_reg;
        diff_next       = diff_reg;
        to_next         = to_reg;
        rsp_valid_next  = rsp_valid_reg;
        out_status_next = out_status_reg;
        out_mapped_next = out_mapped_reg;
        out_off_next    = out_off_reg;
        out_psize_next  = out_psize_reg;
        out_img_next    = out_img_reg;
        mem_we          = 1'b0;
        wr_row          = '{virt_addr: eva_reg, virt_size: size_reg,
                            raw_ptr: erp_reg, raw_size: ers_reg};
        div_req         = '{start: 1'b0, dividend: ru_v_reg, divisor: ru_a_reg};

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next      = req.kind;
                    addr_next      = req.address;
                    size_next      = req.section_size;
                    eva_next       = req.entry_virtual_address;
                    erp_next       = req.entry_raw_pointer;
                    ers_next       = req.entry_raw_size;
                    wk_status_next = STAT_OK;
                    wk_mapped_next = '0;
                    wk_off_next    = '0;
                    wk_psize_next  = '0;
                    wk_img_next    = '0;
                    state_next     = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!valid_cfg_reg)
                begin
                    wk_status_next = STAT_INVALID;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    case (kind_reg)
                        KIND_APPEND:
                        begin
                            if (full)
                            begin
                                wk_status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            state_next = ST_FINISH;
                        end
                        KIND_ADD:
                        begin
                            state_next = ST_ROOM;
                        end
                        default:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                wk_status_next = STAT_NOT_FOUND;
                                state_next     = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_LOOK_RD;
                            end
                        end
                    endcase
                end
            end
            ST_ROOM:
            begin
                op_next = '0;
                if (room_fail)
                begin
                    wk_status_next = STAT_NO_ROOM;
                    state_next     = ST_FINISH;
                end
                else if (full)
                begin
                    wk_status_next = STAT_FULL;
                    state_next     = ST_FINISH;
                end
                else if (count_reg != '0)
                begin
                    state_next = ST_LAST_RD;
                end
                else
                begin
                    base_va_next  = hdr_reg;
                    base_off_next = hdr_reg;
                    state_next    = ST_RU_LOAD;
                end
            end
            ST_LAST_RD:
            begin
                state_next = ST_LAST_SUM;
            end
            ST_LAST_SUM:
            begin
                base_va_next  = rd_reg.virt_addr + rd_reg.virt_size;
                base_off_next = rd_reg.raw_ptr + rd_reg.raw_size;
                state_next    = ST_RU_LOAD;
            end
            ST_RU_LOAD:
            begin
                case (op_reg)
                    2'd0:
                    begin
                        ru_v_next = base_va_reg;
                        ru_a_next = sa_reg;
                    end
                    2'd1:
                    begin
                        ru_v_next = base_off_reg;
                        ru_a_next = fa_reg;
                    end
                    2'd2:
                    begin
                        ru_v_next = size_reg;
                        ru_a_next = fa_reg;
                    end
                    default:
                    begin
                        ru_v_next = wk_mapped_reg + size_reg;
                        ru_a_next = sa_reg;
                    end
                endcase
                state_next = ST_RU_TEST;
            end
            ST_RU_TEST:
            begin
                if (ru_a_reg == '0)
                begin
                    ru_res_next = ru_v_reg;
                    state_next  = ST_RU_STORE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_RU_WAIT;
                end
            end
            ST_RU_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        ru_res_next = ru_v_reg;
                    end
                    else
                    begin
                        ru_res_next = ru_v_reg + (ru_a_reg - div_rsp.remainder);
                    end
                    state_next = ST_RU_STORE;
                end
            end
            ST_RU_STORE:
            begin
                case (op_reg)
                    2'd0:
                    begin
                        wk_mapped_next = ru_res_reg;
                        op_next        = op_reg + 1'b1;
                        state_next     = ST_RU_LOAD;
                    end
                    2'd1:
                    begin
                        wk_off_next = ru_res_reg;
                        op_next     = op_reg + 1'b1;
                        state_next  = ST_RU_LOAD;
                    end
                    2'd2:
                    begin
                        wk_psize_next = ru_res_reg;
                        op_next       = op_reg + 1'b1;
                        state_next    = ST_RU_LOAD;
                    end
                    default:
                    begin
                        wk_img_next = ru_res_reg;
                        mem_we      = 1'b1;
                        wr_row      = '{virt_addr: wk_mapped_reg, virt_size: size_reg,
                                        raw_ptr: wk_off_reg, raw_size: wk_psize_reg};
                        count_next  = count_reg + 1'b1;
                        state_next  = ST_FINISH;
                    end
                endcase
            end
            ST_LOOK_RD:
            begin
                state_next = ST_LOOK_CMP;
            end
            ST_LOOK_CMP:
            begin
                if (hit)
                begin
                    diff_next  = addr_reg - from_base;
                    to_next    = to_base;
                    state_next = ST_LOOK_MAP;
                end
                else if (idx_inc == count_reg)
                begin
                    wk_status_next = STAT_NOT_FOUND;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_LOOK_RD;
                end
            end
            ST_LOOK_MAP:
            begin
                wk_mapped_next = to_reg + diff_reg;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_status_next = wk_status_reg;
                    out_mapped_next = wk_mapped_reg;
                    out_off_next    = wk_off_reg;
                    out_psize_next  = wk_psize_reg;
                    out_img_next    = wk_img_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
        end
        else
        begin
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            op_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            valid_cfg_reg <= 1'b0;
            nt_reg        <= '0;
            hdr_reg       <= '0;
            sa_reg        <= SECTION_ALIGN_RESET;
            fa_reg        <= FILE_ALIGN_RESET;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            op_reg        <= op_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_IMAGE_VALID:      valid_cfg_reg <= cfg.data[0];
                    CFG_NT_HEADER_OFFSET: nt_reg        <= cfg.data;
                    CFG_HEADER_AREA_SIZE: hdr_reg       <= cfg.data;
                    CFG_SECTION_ALIGN:    sa_reg        <= cfg.data;
                    CFG_FILE_ALIGN:       fa_reg        <= cfg.data;
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        addr_reg       <= addr_next;
        size_reg       <= size_next;
        eva_reg        <= eva_next;
        erp_reg        <= erp_next;
        ers_reg        <= ers_next;
        wk_status_reg  <= wk_status_next;
        wk_mapped_reg  <= wk_mapped_next;
        wk_off_reg     <= wk_off_next;
        wk_psize_reg   <= wk_psize_next;
        wk_img_reg     <= wk_img_next;
        base_va_reg    <= base_va_next;
        base_off_reg   <= base_off_next;
        ru_v_reg       <= ru_v_next;
        ru_a_reg       <= ru_a_next;
        ru_res_reg     <= ru_res_next;
        diff_reg       <= diff_next;
        to_reg         <= to_next;
        out_status_reg <= out_status_next;
        out_mapped_reg <= out_mapped_next;
        out_off_reg    <= out_off_next;
        out_psize_reg  <= out_psize_next;
        out_img_reg    <= out_img_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[wr_addr] <= wr_row;
        end
        rd_reg <= table_mem[rd_addr];
    end

    // The table never holds more entries than it has rows.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SECTIONS))
        else $error("entry count beyond table depth");

    // Entries are only ever added one at a time.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count moved by other than one");

    // The remainder unit only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_RU_WAIT))
        else $error("remainder finished outside its wait state");

    // An accepted request is decoded in the following cycle.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted request not dispatched");

    // A finished result is never dropped while the response register is busy.
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && rsp_valid_reg && !rsp.ready)
        |=> (state_reg == ST_FINISH && rsp_valid_reg))
        else $error("result lost while response stalled");

endmodule

// ----- src/stam_rem_unit.sv -----
`timescale 1ns / 1ps
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on stam_pkg.
module stam_rem_unit import stam_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t div_req,
    output div_rsp_t div_rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    dvd_reg, dvd_next;
    logic [WORD_W-1:0]    dsr_reg, dsr_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W:0]      trial;
    logic [WORD_W:0]      diff;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[WORD_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (div_req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(WORD_W - 1);
            dvd_next  = div_req.dividend;
            dsr_next  = div_req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign div_rsp.done      = done_reg;
    assign div_rsp.remainder = rem_reg;

endmodule
